/* design/adtsff_pkg.sv */
// ----------------------------------------------------------------------------
// adtsff_pkg: shared types and constants for the ADTS frame finder
// Holds the event record passed from the byte parser to the timestamp unit,
// the config register codes and the sampling-rate tables.
// ----------------------------------------------------------------------------
package adtsff_pkg;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 32;

    localparam logic [CFG_INDEX_W-1:0] CFG_TS_IN_MS   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_START_TS   = 2'd1;

    localparam logic [7:0]  SYNC_BYTE      = 8'hFF;
    localparam logic [3:0]  SYNC_NIBBLE    = 4'hF;
    localparam logic [12:0] HEADER_LEN     = 13'd7;
    localparam logic [10:0] SAMPLES_PER_FR = 11'd1024;
    localparam logic [3:0]  FIRST_BAD_IDX  = 4'd13;

    // one parser event: frame header found, or buffer end without a header
    typedef struct packed {
        logic        found;
        logic [15:0] offset;
        logic [12:0] length;
        logic [3:0]  rate_index;
    } evt_t;

    typedef struct packed {
        logic                   valid;
        logic [CFG_INDEX_W-1:0] index;
        logic [CFG_DATA_W-1:0]  data;
    } cfg_wr_t;

    function automatic logic [16:0] rate_of(input logic [3:0] idx);
        logic [16:0] r;
        case (idx)
            4'd0:    r = 17'd96000;
            4'd1:    r = 17'd88200;
            4'd2:    r = 17'd64000;
            4'd3:    r = 17'd48000;
            4'd4:    r = 17'd44100;
            4'd5:    r = 17'd32000;
            4'd6:    r = 17'd24000;
            4'd7:    r = 17'd22050;
            4'd8:    r = 17'd16000;
            4'd9:    r = 17'd12000;
            4'd10:   r = 17'd11025;
            4'd11:   r = 17'd8000;
            4'd12:   r = 17'd7350;
            default: r = 17'd0;
        endcase
        return r;
    endfunction

    // 1024000 / rate, truncated
    function automatic logic [7:0] ms_step_of(input logic [3:0] idx);
        logic [7:0] s;
        case (idx)
            4'd0:    s = 8'd10;
            4'd1:    s = 8'd11;
            4'd2:    s = 8'd16;
            4'd3:    s = 8'd21;
            4'd4:    s = 8'd23;
            4'd5:    s = 8'd32;
            4'd6:    s = 8'd42;
            4'd7:    s = 8'd46;
            4'd8:    s = 8'd64;
            4'd9:    s = 8'd85;
            4'd10:   s = 8'd92;
            4'd11:   s = 8'd128;
            4'd12:   s = 8'd139;
            default: s = 8'd0;
        endcase
        return s;
    endfunction

endpackage

/* design/adts_frame_finder.sv */
// A result goes through the event queue and then the output register before it is on m_*.
// Throughput: one byte per cycle; a two-entry event queue feeds the output
// register, so s_tready drops only while the output register and both queue
// entries hold results.
// Reset: synchronous, active low; clears parser state, queue, rate, timestamp
// and the ms-mode flag.
// ----------------------------------------------------------------------------
// adts_frame_finder: ADTS sync search and header parser
// Finds ADTS headers in a byte stream, reports offset, length, rate and a
// running timestamp per frame, and reports buffer ends hit before a header.
// ----------------------------------------------------------------------------
module adts_frame_finder #(
    parameter int TIMESTAMP_WIDTH = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] stream_byte
    input  logic        s_tlast,    // buffer_end
    output logic        m_tvalid,
    input  logic        m_tready,
    // [15:0] frame_offset, [28:16] frame_length, [32:29] rate_index,
    // [49:33] sample_rate, [50] bad_index, [82:51] frame_timestamp, [87:83] zero
    output logic [87:0] m_tdata,
    output logic        m_tuser,    // found
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [adtsff_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [adtsff_pkg::CFG_DATA_W-1:0]  cfg_data
);

    adtsff_pkg::evt_t    push_evt, head_evt;
    adtsff_pkg::cfg_wr_t cfg_wr;
    logic        push, q_full, q_pop, q_not_empty;
    logic [15:0] o_offset;
    logic [12:0] o_length;
    logic [3:0]  o_idx;
    logic [16:0] o_rate;
    logic        o_bad;
    logic [31:0] o_ts;

    assign cfg_ready    = 1'b1;
    assign cfg_wr.valid = cfg_valid;
    assign cfg_wr.index = cfg_index;
    assign cfg_wr.data  = cfg_data;

    adtsff_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_byte  (s_tdata),
        .in_last  (s_tlast),
        .q_full   (q_full),
        .push     (push),
        .push_evt (push_evt)
    );

    adtsff_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_evt  (push_evt),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head_evt  (head_evt)
    );

    adtsff_back #(
        .TIMESTAMP_WIDTH (TIMESTAMP_WIDTH)
    ) u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr          (cfg_wr),
        .q_not_empty     (q_not_empty),
        .q_head          (head_evt),
        .q_pop           (q_pop),
        .out_valid       (m_tvalid),
        .out_ready       (m_tready),
        .out_found       (m_tuser),
        .out_offset      (o_offset),
        .out_length      (o_length),
        .out_rate_index  (o_idx),
        .out_sample_rate (o_rate),
        .out_bad_index   (o_bad),
        .out_timestamp   (o_ts)
    );

    assign m_tdata = {5'd0, o_ts, o_bad, o_rate, o_idx, o_length, o_offset};

endmodule

/* design/adtsff_front.sv */
// ----------------------------------------------------------------------------
// adtsff_front: byte parser
// Hunts for ADTS sync, collects the header, skips the frame body and emits
// one event per found header or per buffer end seen outside a frame body.
// ----------------------------------------------------------------------------
module adtsff_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [7:0]        in_byte,
    input  logic              in_last,
    input  logic              q_full,
    output logic              push,
    output adtsff_pkg::evt_t  push_evt
);

    typedef enum logic [1:0] {
        PH_HUNT,
        PH_HEADER,
        PH_SKIP
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [2:0]  cnt_reg, cnt_next;
    logic [7:0]  hb_reg [4];
    logic [7:0]  hb_next [4];
    logic [12:0] skip_reg, skip_next;
    logic [15:0] skipped_reg, skipped_next;
    logic        ff_reg, ff_next;
    logic        accept;

    function automatic logic [15:0] sat_inc(input logic [15:0] v);
        return (v == 16'hFFFF) ? v : v + 16'd1;
    endfunction

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;

    always_comb begin
        logic [12:0] len;
        logic [3:0]  idx;
        logic [12:0] dec;
        logic [15:0] s;
        logic        ff;
        logic [1:0]  slot;

        phase_next   = phase_reg;
        cnt_next     = cnt_reg;
        hb_next      = hb_reg;
        skip_next    = skip_reg;
        skipped_next = skipped_reg;
        ff_next      = ff_reg;
        push         = 1'b0;
        push_evt     = '0;
        len  = {hb_reg[1][1:0], hb_reg[2], hb_reg[3][7:5]};
        idx  = hb_reg[0][5:2];
        dec  = (skip_reg != 13'd0) ? skip_reg - 13'd1 : skip_reg;
        s    = skipped_reg;
        ff   = ff_reg;
        slot = 2'(cnt_reg - 3'd2);

        if (accept) begin
            unique case (phase_reg)
                PH_SKIP: begin
                    skip_next = dec;
                    if (dec == 13'd0) begin
                        phase_next = PH_HUNT;
                    end
                end
                PH_HEADER: begin
                    if (cnt_reg >= 3'd2 && cnt_reg <= 3'd5) begin
                        hb_next[slot] = in_byte;
                    end
                    if (cnt_reg >= 3'd6) begin
                        push                = 1'b1;
                        push_evt.found      = 1'b1;
                        push_evt.offset     = skipped_reg;
                        push_evt.length     = len;
                        push_evt.rate_index = idx;
                        skipped_next        = '0;
                        ff_next             = 1'b0;
                        cnt_next            = '0;
                        skip_next  = (len >= adtsff_pkg::HEADER_LEN) ?
                                     len - adtsff_pkg::HEADER_LEN : 13'd0;
                        phase_next = (len > adtsff_pkg::HEADER_LEN) ? PH_SKIP : PH_HUNT;
                    end else if (in_last) begin
                        // partial header dropped
                        push            = 1'b1;
                        push_evt.offset = skipped_reg;
                        skipped_next    = '0;
                        cnt_next        = '0;
                        phase_next      = PH_HUNT;
                    end else begin
                        cnt_next = cnt_reg + 3'd1;
                    end
                end
                default: begin
                    phase_next = PH_HUNT;
                    if (ff_reg && in_byte[7:4] == adtsff_pkg::SYNC_NIBBLE) begin
                        ff         = 1'b0;
                        cnt_next   = 3'd2;
                        phase_next = PH_HEADER;
                    end else begin
                        if (ff_reg) begin
                            s = sat_inc(s);
                        end
                        if (in_byte == adtsff_pkg::SYNC_BYTE) begin
                            ff = 1'b1;
                        end else begin
                            ff = 1'b0;
                            s  = sat_inc(s);
                        end
                    end
                    if (in_last) begin
                        // pending 0xFF counts as skipped
                        if (ff) begin
                            s = sat_inc(s);
                        end
                        ff              = 1'b0;
                        push            = 1'b1;
                        push_evt.offset = s;
                        s               = '0;
                        cnt_next        = '0;
                        phase_next      = PH_HUNT;
                    end
                    skipped_next = s;
                    ff_next      = ff;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_HUNT;
            cnt_reg     <= '0;
            skip_reg    <= '0;
            skipped_reg <= '0;
            ff_reg      <= 1'b0;
            for (int i = 0; i < 4; i++) begin
                hb_reg[i] <= '0;
            end
        end else begin
            phase_reg   <= phase_next;
            cnt_reg     <= cnt_next;
            skip_reg    <= skip_next;
            skipped_reg <= skipped_next;
            ff_reg      <= ff_next;
            hb_reg      <= hb_next;
        end
    end

endmodule

/* design/adtsff_queue.sv */
// ----------------------------------------------------------------------------
// adtsff_queue: two-entry event queue
// Decouples the byte parser from the timestamp unit and output register.
// ----------------------------------------------------------------------------
module adtsff_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  adtsff_pkg::evt_t  push_evt,
    output logic              full,
    input  logic              pop,
    output logic              not_empty,
    output adtsff_pkg::evt_t  head_evt
);

    adtsff_pkg::evt_t mem_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       do_push, do_pop;

    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign head_evt  = mem_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    always_comb begin
        wr_ptr_next = do_push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 2'd1;
        end else if (!do_push && do_pop) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_evt;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

/* design/adtsff_back.sv */
// ----------------------------------------------------------------------------
// adtsff_back: rate lookup, timestamp and output register
// Pops parser events, keeps the current rate and running timestamp, and
// holds one finished result until the consumer takes it.
// ----------------------------------------------------------------------------
module adtsff_back #(
    parameter int TIMESTAMP_WIDTH = 32
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  adtsff_pkg::cfg_wr_t cfg_wr,
    input  logic                q_not_empty,
    input  adtsff_pkg::evt_t    q_head,
    output logic                q_pop,
    output logic                out_valid,
    input  logic                out_ready,
    output logic                out_found,
    output logic [15:0]         out_offset,
    output logic [12:0]         out_length,
    output logic [3:0]          out_rate_index,
    output logic [16:0]         out_sample_rate,
    output logic                out_bad_index,
    output logic [31:0]         out_timestamp
);

    logic                       ts_ms_reg;
    logic [TIMESTAMP_WIDTH-1:0] ts_reg, ts_next;
    logic [16:0]                rate_reg, rate_next;
    logic [7:0]                 ms_step_reg, ms_step_next;
    logic                       valid_reg;
    logic                       found_reg;
    logic [15:0]                offset_reg;
    logic [12:0]                length_reg;
    logic [3:0]                 idx_reg;
    logic [16:0]                orate_reg;
    logic                       bad_reg;
    logic [31:0]                ots_reg;
    logic                       bad;
    logic [TIMESTAMP_WIDTH-1:0] step;

    assign q_pop = q_not_empty && (!valid_reg || out_ready);
    assign bad   = (q_head.rate_index >= adtsff_pkg::FIRST_BAD_IDX);

    always_comb begin
        rate_next    = rate_reg;
        ms_step_next = ms_step_reg;
        if (!bad) begin
            rate_next    = adtsff_pkg::rate_of(q_head.rate_index);
            ms_step_next = adtsff_pkg::ms_step_of(q_head.rate_index);
        end
        step    = ts_ms_reg ? TIMESTAMP_WIDTH'(ms_step_next)
                            : TIMESTAMP_WIDTH'(adtsff_pkg::SAMPLES_PER_FR);
        ts_next = ts_reg + step;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ts_ms_reg   <= 1'b0;
            ts_reg      <= '0;
            rate_reg    <= '0;
            ms_step_reg <= '0;
            valid_reg   <= 1'b0;
        end else begin
            if (cfg_wr.valid) begin
                if (cfg_wr.index == adtsff_pkg::CFG_TS_IN_MS) begin
                    ts_ms_reg <= cfg_wr.data[0];
                end else if (cfg_wr.index == adtsff_pkg::CFG_START_TS) begin
                    ts_reg <= TIMESTAMP_WIDTH'(cfg_wr.data);
                end
            end
            if (q_pop) begin
                valid_reg <= 1'b1;
                if (q_head.found) begin
                    ts_reg      <= ts_next;
                    rate_reg    <= rate_next;
                    ms_step_reg <= ms_step_next;
                end
            end else if (out_ready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            found_reg  <= q_head.found;
            offset_reg <= q_head.offset;
            length_reg <= q_head.length;
            idx_reg    <= q_head.rate_index;
            if (q_head.found) begin
                orate_reg <= rate_next;
                bad_reg   <= bad;
                ots_reg   <= 32'(ts_next);
            end else begin
                orate_reg <= '0;
                bad_reg   <= 1'b0;
                ots_reg   <= '0;
            end
        end
    end

    assign out_valid       = valid_reg;
    assign out_found       = found_reg;
    assign out_offset      = offset_reg;
    assign out_length      = length_reg;
    assign out_rate_index  = idx_reg;
    assign out_sample_rate = orate_reg;
    assign out_bad_index   = bad_reg;
    assign out_timestamp   = ots_reg;

endmodule

/* test/adts_frame_finder_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// adts_frame_finder_tb: self-checking bench for the ADTS frame finder
// Drives ADTS-like byte streams, both clean frames and corrupted ones, into
// the finder. A built-in parser model predicts each report, and every
// report on the output stream is checked field by field against it. Random
// stalls are applied on both sides.
// ----------------------------------------------------------------------------
module adts_frame_finder_tb;

    localparam int          SETTLE_CYCLES  = 8;
    localparam int          RX_HOLD_CYCLES = 400;
    localparam logic [31:0] FRAME_MS_SCALE = 32'd1024000;   // 1024 samples in ms * rate

    typedef enum logic [1:0] {SEEK_SYNC, IN_HEADER, SKIP_BODY} parse_phase_t;

    typedef struct packed {
        logic        found;
        logic [15:0] offset;
        logic [12:0] length;
        logic [3:0]  rate_idx;
        logic [16:0] rate;
        logic        bad;
        logic [31:0] stamp;
    } frame_report_t;

    logic                               aclk      = 1'b0;
    logic                               aresetn   = 1'b0;
    logic                               s_tvalid  = 1'b0;
    logic                               s_tready;
    logic [7:0]                         s_tdata   = '0;
    logic                               s_tlast   = 1'b0;
    logic                               m_tvalid;
    logic                               m_tready  = 1'b0;
    logic [87:0]                        m_tdata;
    logic                               m_tuser;
    logic                               cfg_valid = 1'b0;
    logic                               cfg_ready;
    logic [adtsff_pkg::CFG_INDEX_W-1:0] cfg_index = adtsff_pkg::CFG_TS_IN_MS;
    logic [adtsff_pkg::CFG_DATA_W-1:0]  cfg_data  = '0;

    // parser model state
    parse_phase_t parse_phase = SEEK_SYNC;
    int           hdr_count   = 0;
    logic [7:0]   hdr_byte [4];
    logic [12:0]  body_left   = '0;
    logic [15:0]  skipped     = '0;
    logic [31:0]  run_ts      = '0;
    logic [16:0]  cur_rate    = '0;
    logic         ff_pending  = 1'b0;
    logic         ms_mode     = 1'b0;

    int unsigned rate_hz [13] = '{96000, 88200, 64000, 48000, 44100, 32000, 24000,
                                  22050, 16000, 12000, 11025, 8000, 7350};

    frame_report_t pending_reports [$];

    int unsigned mismatches   = 0;
    int unsigned frames_seen  = 0;
    int unsigned misses_seen  = 0;
    int unsigned bytes_sent   = 0;
    int unsigned search_bytes = 0;
    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    bit          rx_hold_req   = 1'b0;
    int          rx_hold_left  = 0;

    adts_frame_finder dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 aclk = ~aclk;

    initial begin
        #20ms;
        $display("adts_frame_finder_tb: FAIL");
        $finish;
    end

    // ------------------------------------------------------------------------
    // parser model
    // ------------------------------------------------------------------------
    function automatic void bump_skipped();
        if (skipped != 16'hFFFF) skipped++;
    endfunction

    task automatic predict_byte(input logic [7:0] b, input logic last);
        frame_report_t rec;
        logic [3:0]    idx;
        logic [12:0]   len;
        logic [31:0]   step;
        rec = '0;
        if (parse_phase == SKIP_BODY) begin
            if (body_left != 0) body_left--;
            if (body_left == 0) parse_phase = SEEK_SYNC;
        end else if (parse_phase == IN_HEADER) begin
            if (hdr_count < 6) begin
                hdr_byte[hdr_count-2] = b;
                hdr_count++;
                if (last) begin
                    rec.offset  = skipped;
                    skipped     = '0;
                    hdr_count   = 0;
                    parse_phase = SEEK_SYNC;
                    pending_reports.push_back(rec);
                end
            end else begin
                // seventh header byte: buffer end here does not matter
                idx = hdr_byte[0][5:2];
                len = {hdr_byte[1][1:0], hdr_byte[2], hdr_byte[3][7:5]};
                if (idx < adtsff_pkg::FIRST_BAD_IDX) cur_rate = 17'(rate_hz[idx]);
                if (!ms_mode) step = 32'(adtsff_pkg::SAMPLES_PER_FR);
                else if (cur_rate != 0) step = FRAME_MS_SCALE / cur_rate;
                else step = '0;
                run_ts       = run_ts + step;
                rec.found    = 1'b1;
                rec.offset   = skipped;
                rec.length   = len;
                rec.rate_idx = idx;
                rec.rate     = cur_rate;
                rec.bad      = (idx >= adtsff_pkg::FIRST_BAD_IDX);
                rec.stamp    = run_ts;
                skipped      = '0;
                ff_pending   = 1'b0;
                hdr_count    = 0;
                body_left    = (len >= adtsff_pkg::HEADER_LEN) ?
                               len - adtsff_pkg::HEADER_LEN : '0;
                parse_phase  = (body_left != 0) ? SKIP_BODY : SEEK_SYNC;
                pending_reports.push_back(rec);
            end
        end else begin
            if (ff_pending && b[7:4] == adtsff_pkg::SYNC_NIBBLE) begin
                ff_pending  = 1'b0;
                hdr_count   = 2;
                parse_phase = IN_HEADER;
            end else begin
                if (ff_pending) bump_skipped();
                if (b == adtsff_pkg::SYNC_BYTE) begin
                    ff_pending = 1'b1;
                end else begin
                    ff_pending = 1'b0;
                    bump_skipped();
                end
            end
            if (last) begin
                if (ff_pending) bump_skipped();
                ff_pending  = 1'b0;
                rec.offset  = skipped;
                skipped     = '0;
                hdr_count   = 0;
                parse_phase = SEEK_SYNC;
                pending_reports.push_back(rec);
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // report checker; inputs only move at rising edges, so the falling edge
    // sees exactly what the next rising edge will take
    // ------------------------------------------------------------------------
    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
        end
    endfunction

    always @(negedge aclk) begin : report_check
        frame_report_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_reports.size() == 0) begin
                $error("report with none expected: found=%0b offset=%0d", m_tuser,
                       m_tdata[15:0]);
                mismatches++;
            end else begin
                want = pending_reports.pop_front();
                if (want.found) frames_seen++;
                else misses_seen++;
                check_field("found", 32'(want.found), 32'(m_tuser));
                check_field("frame_offset", 32'(want.offset), 32'(m_tdata[15:0]));
                check_field("frame_length", 32'(want.length), 32'(m_tdata[28:16]));
                check_field("rate_index", 32'(want.rate_idx), 32'(m_tdata[32:29]));
                check_field("sample_rate", 32'(want.rate), 32'(m_tdata[49:33]));
                check_field("bad_index", 32'(want.bad), 32'(m_tdata[50]));
                check_field("frame_timestamp", want.stamp, m_tdata[82:51]);
            end
        end
    end

    // receiver: random stalls, or a long hold-off counted here
    always @(posedge aclk) begin
        if (rx_hold_req) begin
            rx_hold_left = RX_HOLD_CYCLES;
            rx_hold_req  = 1'b0;
        end
        if (rx_hold_left != 0) begin
            rx_hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // ------------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------------
    task automatic send_byte(input logic [7:0] b, input logic last, input bit in_body);
        bit took;
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        do begin
            @(negedge aclk);
            took = s_tready;
            @(posedge aclk);
        end while (!took);
        predict_byte(b, last);
        bytes_sent++;
        if (!in_body) search_bytes++;
    endtask

    task automatic write_reg(input logic [adtsff_pkg::CFG_INDEX_W-1:0] index,
                             input logic [31:0] value);
        bit took;
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        do begin
            @(negedge aclk);
            took = cfg_ready;
            @(posedge aclk);
        end while (!took);
        cfg_valid <= 1'b0;
        @(posedge aclk);
        if (index == adtsff_pkg::CFG_TS_IN_MS) ms_mode = value[0];
        else if (index == adtsff_pkg::CFG_START_TS) run_ts = value;
    endtask

    // stop offering bytes until every report is in and the block is quiet
    task automatic drain_reports();
        s_tvalid <= 1'b0;
        while (pending_reports.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    function automatic logic [55:0] adts_header(input logic [3:0] idx, input logic [12:0] len);
        logic [55:0] h;
        logic [31:0] r0;
        logic [31:0] r1;
        r0 = $urandom;
        r1 = $urandom;
        h = {r1[23:0], r0};
        h[7:0]   = adtsff_pkg::SYNC_BYTE;
        h[15:12] = adtsff_pkg::SYNC_NIBBLE;
        h[21:18] = idx;
        h[25:24] = len[12:11];
        h[39:32] = len[10:3];
        h[47:45] = len[2:0];
        return h;
    endfunction

    // cut_at: header byte carrying a buffer end, negative for none
    task automatic send_frame(input logic [55:0] hdr, input int cut_at,
                              input int unsigned body_last_pct);
        logic [12:0] len;
        len = {hdr[25:24], hdr[39:32], hdr[47:45]};
        for (int i = 0; i < 7; i++) begin
            send_byte(hdr[8*i +: 8], i == cut_at, 1'b0);
            if (i == cut_at && i < 6) return;
        end
        for (int j = 7; j < int'(len); j++)
            send_byte(8'($urandom), $urandom_range(99) < body_last_pct, 1'b1);
    endtask

    // feed filler until the model is hunting with no 0xFF pending; inside a
    // header the filler keeps the length field short
    task automatic settle_parser();
        while (parse_phase != SEEK_SYNC || ff_pending) begin
            if (parse_phase == IN_HEADER)
                send_byte(8'($urandom_range(7) << 2), $urandom_range(99) < 3, 1'b1);
            else
                send_byte(8'($urandom_range(8'hEF)), $urandom_range(99) < 3, 1'b1);
        end
    endtask

    function automatic logic [12:0] random_length();
        int unsigned p;
        p = $urandom_range(99);
        if (p < 10) return 13'($urandom_range(6));
        if (p < 85) return 13'($urandom_range(40, 7));
        return 13'($urandom_range(120, 41));
    endfunction

    task automatic send_random_sequence();
        int unsigned pick;
        int unsigned n;
        logic [55:0] h;
        pick = $urandom_range(99);
        if (pick < 72) begin
            n = ($urandom_range(9) == 0) ? $urandom_range(30) : $urandom_range(2);
            repeat (n) send_byte(8'($urandom_range(8'hFE)), $urandom_range(99) < 4, 1'b0);
            send_frame(adts_header(4'($urandom), random_length()),
                       ($urandom_range(99) < 5) ? int'($urandom_range(6)) : -1, 4);
        end else if (pick < 86) begin
            case ($urandom_range(2))
                0: begin
                    send_byte(adtsff_pkg::SYNC_BYTE, 1'b0, 1'b0);
                    send_byte(8'($urandom_range(8'hEF)), $urandom_range(99) < 20, 1'b0);
                end
                1: send_frame(adts_header(4'($urandom), random_length()),
                              int'($urandom_range(5)), 4);
                default: begin
                    // stray 0xFF ahead of a frame shifts the header by one byte;
                    // the bits read as the shifted length are cleared
                    h = adts_header(4'($urandom), 13'd7);
                    h[17:16] = 2'b00;
                    h[31:26] = 6'd0;
                    send_byte(adtsff_pkg::SYNC_BYTE, 1'b0, 1'b0);
                    send_frame(h, -1, 4);
                end
            endcase
        end else begin
            n = $urandom_range(8, 1);
            // stop at a sync so the header is built from short filler
            for (int i = 0; i < int'(n) && parse_phase == SEEK_SYNC; i++)
                send_byte(($urandom_range(2) == 0) ? adtsff_pkg::SYNC_BYTE : 8'($urandom),
                          $urandom_range(99) < 20, 1'b0);
        end
        settle_parser();
    endtask

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------
    task automatic test_rate_zero_in_ms();
        write_reg(adtsff_pkg::CFG_TS_IN_MS, 32'd1);
        write_reg(adtsff_pkg::CFG_START_TS, 32'd0);
        // no valid index seen yet: rate is zero, timestamp must not move
        send_frame(adts_header(4'd13, 13'd7), -1, 0);
        send_frame(adts_header(4'd15, 13'd0), -1, 0);
        send_frame(adts_header(4'd0, 13'd7), -1, 0);
        send_frame(adts_header(4'd14, 13'd7), -1, 0);
        drain_reports();
    endtask

    task automatic test_sync_corners();
        logic [55:0] h;
        h = adts_header(4'd3, 13'd7);
        h[15:8] = adtsff_pkg::SYNC_BYTE;                 // 0xFF 0xFF opens a header
        send_frame(h, -1, 0);
        send_byte(adtsff_pkg::SYNC_BYTE, 1'b0, 1'b0);    // 0xFF not followed by sync nibble
        send_byte(8'h7E, 1'b0, 1'b0);
        send_byte(8'h00, 1'b1, 1'b0);
        send_byte(adtsff_pkg::SYNC_BYTE, 1'b1, 1'b0);    // pending 0xFF dropped at buffer end
        send_frame(adts_header(4'd7, 13'd7), 1, 0);
        send_frame(adts_header(4'd8, 13'd7), 3, 0);
        send_frame(adts_header(4'd9, 13'd9), 6, 0);     // buffer end on last header byte
        send_frame(adts_header(4'd10, 13'd10), -1, 100); // buffer ends inside the body
        drain_reports();
    endtask

    task automatic test_lengths();
        send_frame(adts_header(4'd11, 13'd0), -1, 0);
        send_frame(adts_header(4'd12, 13'd6), -1, 0);
        send_frame(adts_header(4'd1, 13'd8), -1, 0);
        send_frame(adts_header(4'd15, 13'd64), -1, 0);
        send_frame(adts_header(4'd2, 13'd7), -1, 0);
        drain_reports();
    endtask

    task automatic test_long_gap();
        repeat (120) send_byte(8'($urandom_range(8'hFE)), 1'b0, 1'b0);
        send_frame(adts_header(4'd4, 13'd7), -1, 0);
        repeat (80) send_byte(8'($urandom_range(8'hFE)), 1'b0, 1'b0);
        send_byte(8'h00, 1'b1, 1'b0);
        drain_reports();
    endtask

    task automatic test_timestamp_wrap();
        write_reg(adtsff_pkg::CFG_TS_IN_MS, 32'd0);
        write_reg(adtsff_pkg::CFG_START_TS, 32'hFFFF_FE00);
        repeat (3) send_frame(adts_header(4'd5, 13'd7), -1, 0);
        drain_reports();
        write_reg(adtsff_pkg::CFG_TS_IN_MS, 32'd1);
        write_reg(adtsff_pkg::CFG_START_TS, 32'hFFFF_FFFF);
        send_frame(adts_header(4'd12, 13'd7), -1, 0);
        send_frame(adts_header(4'd6, 13'd7), -1, 0);
        drain_reports();
    endtask

    task automatic test_output_backpressure();
        s_tvalid <= 1'b0;
        @(negedge aclk);
        rx_hold_req = 1'b1;
        @(posedge aclk);
        // every byte ends a buffer, so each one is a report that has to queue up
        repeat (40) send_byte(8'($urandom), 1'b1, 1'b0);
        drain_reports();
    endtask

    task automatic test_random_traffic(input int unsigned target, input logic ms,
                                       input logic [31:0] start_ts);
        int unsigned base;
        drain_reports();
        write_reg(adtsff_pkg::CFG_TS_IN_MS, {31'd0, ms});
        write_reg(adtsff_pkg::CFG_START_TS, start_ts);
        base = bytes_sent;
        while (bytes_sent - base < target) send_random_sequence();
        drain_reports();
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_idle_pct = 10;
        recv_idle_pct = 69;
        test_rate_zero_in_ms();
        test_sync_corners();
        test_lengths();
        test_long_gap();
        test_timestamp_wrap();
        test_random_traffic(330, 1'b0, $urandom);

        send_idle_pct = 69;
        recv_idle_pct = 10;
        test_random_traffic(330, 1'b1, 32'hFFFF_FFFF);
        test_output_backpressure();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_traffic(340, $urandom_range(1), 32'd0);

        drain_reports();
        $display("summary: %0d bytes sent, %0d of them outside frame bodies, through",
                 bytes_sent, search_bytes);
        $display("summary: sync hunt, header parse and body skip; %0d frame reports and %0d %s",
                 frames_seen, misses_seen, "buffer-end reports checked");
        if (mismatches == 0 && pending_reports.size() == 0) begin
            $display("adts_frame_finder_tb: PASS");
        end else begin
            $display("adts_frame_finder_tb: FAIL");
        end
        $finish;
    end

endmodule

/* sim.f */
design/adtsff_pkg.sv
design/adtsff_front.sv
design/adtsff_queue.sv
design/adtsff_back.sv
design/adts_frame_finder.sv
test/adts_frame_finder_tb.sv
